>>> src/vzz_pkg.sv
// Shared types and constants for the varint / zigzag codec.
// No dependencies; the codec, front end, queue, back end and testbench import this package.
`timescale 1ns / 1ps

package vzz_pkg;

  // input mode codes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // byte counts that end a value, and the highest group index
  localparam logic [3:0] MAX_BYTES_W32 = 4'd5;
  localparam logic [3:0] MAX_BYTES_W64 = 4'd10;
  localparam logic [3:0] MAX_GROUP_IDX = 4'd9;

  localparam int GROUP_BITS = 7;

  // kind of work queued between front and back
  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } vzz_cmd_e;

  // kind of result word
  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_VALUE = 1'b1
  } vzz_kind_e;

  // one queued command: mapped value to serialise, or finished decoded value
  typedef struct packed {
    vzz_cmd_e    kind;
    logic [63:0] data;
    logic        trunc;
  } vzz_cmd_t;

endpackage

>>> src/vzz_if.sv
// Valid/ready channel interfaces for the codec's input and result words.
// No dependencies.
`timescale 1ns / 1ps

interface vzz_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [63:0] value;
  logic        is_signed;
  logic        wide;
  logic [7:0]  in_byte;

  modport source (output valid, mode, value, is_signed, wide, in_byte, input ready);
  modport sink   (input valid, mode, value, is_signed, wide, in_byte, output ready);
endinterface

interface vzz_out_if;
  logic        valid;
  logic        ready;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic [63:0] out_value;
  logic        last;
  logic        truncated;

  modport source (output valid, out_kind, out_byte, out_value, last, truncated, input ready);
  modport sink   (input valid, out_kind, out_byte, out_value, last, truncated, output ready);
endinterface

>>> src/varint_zigzag_codec.sv
// Varint (base-128) codec with optional zigzag mapping, 32- or 64-bit width.
// A decode word (one byte) is taken every cycle unless the queue is full; the
// value passes through the command queue and the output register. An encode
// word yields 1 to 5 (32-bit) or 1 to 10 (64-bit) byte words, one per cycle
// from the back-end serialiser while the output is ready, so encode throughput
// is then one output byte per cycle. A command queue of QUEUE_DEPTH entries
// sits between the front end and the serialiser; the input stalls only when
// that queue is full. Depends on vzz_pkg, vzz_if, vzz_front, vzz_fifo and vzz_back.
`timescale 1ns / 1ps

module varint_zigzag_codec import vzz_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  vzz_in_if.sink    in_chan,
  vzz_out_if.source out_chan
);

  logic     push;
  vzz_cmd_t push_cmd;
  logic     full;
  logic     pop;
  vzz_cmd_t head;
  logic     head_valid;

  // accept and classify
  vzz_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  // command queue
  vzz_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // serialise and present results
  vzz_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

>>> src/vzz_front.sv
// Front end: accepts input words, zigzag-maps encode values and
// accumulates decode bytes, queueing one command per finished value. Uses vzz_pkg.
`timescale 1ns / 1ps

module vzz_front import vzz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  vzz_in_if.sink    in_chan,
  output logic      push,
  output vzz_cmd_t  push_cmd,
  input  logic      full
);

  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  logic        accept;
  logic        is_dec;
  logic [3:0]  cnt_c;
  logic [3:0]  cnt_inc;
  logic [5:0]  shamt;
  logic [63:0] acc_c;
  logic [3:0]  max_bytes;
  logic        dec_done;
  logic        dec_trunc;
  logic [63:0] dec_val;
  logic [31:0] dec_lo;
  logic [31:0] dec_um32;
  logic [63:0] enc_val;

  assign in_chan.ready = !full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_dec        = (in_chan.mode == MODE_DECODE);

  // place the incoming group at its position
  always_comb begin
    cnt_c     = (cnt_r > MAX_GROUP_IDX) ? MAX_GROUP_IDX : cnt_r;
    cnt_inc   = cnt_c + 4'd1;
    shamt     = {2'b00, cnt_c} * 6'(GROUP_BITS);
    acc_c     = acc_r | ({57'd0, in_chan.in_byte[6:0]} << shamt);
    max_bytes = in_chan.wide ? MAX_BYTES_W64 : MAX_BYTES_W32;
    dec_trunc = in_chan.in_byte[7] && (cnt_inc >= max_bytes);
    dec_done  = !in_chan.in_byte[7] || dec_trunc;
  end

  // cut to width and undo zigzag
  always_comb begin
    dec_lo   = acc_c[31:0];
    dec_um32 = {1'b0, dec_lo[31:1]} ^ {32{dec_lo[0]}};
    if (in_chan.wide) begin
      dec_val = in_chan.is_signed ? ({1'b0, acc_c[63:1]} ^ {64{acc_c[0]}}) : acc_c;
    end else begin
      dec_val = in_chan.is_signed ? {{32{dec_um32[31]}}, dec_um32} : {32'd0, dec_lo};
    end
  end

  // cut to width and apply zigzag
  always_comb begin
    if (in_chan.wide) begin
      enc_val = in_chan.is_signed
              ? ({in_chan.value[62:0], 1'b0} ^ {64{in_chan.value[63]}})
              : in_chan.value;
    end else begin
      enc_val = in_chan.is_signed
              ? {32'd0, {in_chan.value[30:0], 1'b0} ^ {32{in_chan.value[31]}}}
              : {32'd0, in_chan.value[31:0]};
    end
  end

  // queue write and decode state update
  always_comb begin
    push           = accept && (!is_dec || dec_done);
    push_cmd.kind  = is_dec ? CMD_DECODE : CMD_ENCODE;
    push_cmd.data  = is_dec ? dec_val : enc_val;
    push_cmd.trunc = is_dec && dec_trunc;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    if (accept && is_dec) begin
      if (dec_done) begin
        acc_nxt = 64'd0;
        cnt_nxt = 4'd0;
      end else begin
        acc_nxt = acc_c;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= 64'd0;
      cnt_r <= 4'd0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // a stored count always leaves room for one more group
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_GROUP_IDX)
    else $error("decode count beyond last group index");

endmodule

>>> src/vzz_fifo.sv
// Short command queue between front and back, so each side stalls on its own.
// Uses vzz_pkg for the command type.
`timescale 1ns / 1ps

module vzz_fifo import vzz_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  vzz_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output vzz_cmd_t head,
  output logic     head_valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vzz_cmd_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // the front never offers a command into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full command queue");

endmodule

>>> src/vzz_back.sv
// Back end: serialises queued encode values into 7-bit groups, one byte a cycle
// when not stalled, and forwards decoded values, through an output register. Uses vzz_pkg.
`timescale 1ns / 1ps

module vzz_back import vzz_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  vzz_cmd_t  head,
  input  logic      head_valid,
  output logic      pop,
  vzz_out_if.source out_chan
);

  logic        active_r, active_nxt;
  logic [63:0] v_r, v_nxt;
  logic [3:0]  n_r, n_nxt;

  logic        out_valid_r, out_valid_nxt;
  vzz_kind_e   kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [63:0] value_r, value_nxt;
  logic        last_r, last_nxt;
  logic        trunc_r, trunc_nxt;

  logic        slot_free;
  logic        load_out;
  logic        is_enc;
  logic [63:0] src_v;
  logic [3:0]  src_n;
  logic        enc_last;
  logic [7:0]  enc_byte;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign pop       = slot_free && !active_r && head_valid;
  assign load_out  = slot_free && (active_r || head_valid);
  assign is_enc    = active_r || (head.kind == CMD_ENCODE);

  // next group of the value being serialised
  always_comb begin
    src_v    = active_r ? v_r : head.data;
    src_n    = active_r ? n_r : 4'd0;
    enc_last = (src_v[63:7] == '0) || (src_n == MAX_GROUP_IDX);
    enc_byte = enc_last ? src_v[7:0] : {1'b1, src_v[6:0]};
  end

  // serialiser and output register
  always_comb begin
    active_nxt    = active_r;
    v_nxt         = v_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    value_nxt     = value_r;
    last_nxt      = last_r;
    trunc_nxt     = trunc_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      if (is_enc) begin
        active_nxt = !enc_last;
        v_nxt      = src_v >> GROUP_BITS;
        n_nxt      = src_n + 4'd1;
        kind_nxt   = KIND_BYTE;
        byte_nxt   = enc_byte;
        value_nxt  = 64'd0;
        last_nxt   = enc_last;
        trunc_nxt  = 1'b0;
      end else begin
        kind_nxt   = KIND_VALUE;
        byte_nxt   = 8'd0;
        value_nxt  = head.data;
        last_nxt   = 1'b0;
        trunc_nxt  = head.trunc;
      end
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    n_r     <= n_nxt;
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
    trunc_r <= trunc_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.out_kind  = kind_r;
  assign out_chan.out_byte  = byte_r;
  assign out_chan.out_value = value_r;
  assign out_chan.last      = last_r;
  assign out_chan.truncated = trunc_r;

  // a value in flight has between one and nine groups already sent
  a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (n_r != 4'd0 && n_r <= MAX_GROUP_IDX))
    else $error("serialiser group index out of range");

  // a non-final encoded byte carries the continuation bit
  a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_BYTE && !last_r) |-> byte_r[7])
    else $error("continuation bit missing on non-final byte");

  // while a value is still being serialised, the queue is not read
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> !pop)
    else $error("queue read while serialising");

endmodule

>>> dv/varint_zigzag_codec_test.sv
// Self-checking testbench for varint_zigzag_codec: a directed stimulus table, then random
// encode words, decode byte streams and noise, checked against typed results or a local model of the codec.
// Depends on vzz_pkg, vzz_if and the varint_zigzag_codec RTL.
`timescale 1ns / 1ps

module varint_zigzag_codec_test;
  import vzz_pkg::*;

  localparam int RANDOM_WORDS = 76;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;

  // one input word and one result word
  typedef struct packed {
    logic        mode;
    logic [63:0] value;
    logic        is_signed;
    logic        wide;
    logic [7:0]  in_byte;
  } codec_in_t;

  typedef struct packed {
    vzz_kind_e   kind;
    logic [7:0]  enc_byte;
    logic [63:0] dec_value;
    logic        last;
    logic        truncated;
  } codec_res_t;

  // directed row: result typed in by hand only when typed is set
  typedef struct packed {
    codec_in_t  word;
    logic       typed;
    codec_res_t res;
  } codec_row_t;

  localparam codec_res_t NO_RESULT = '0;

  logic clk;
  logic rst_n;

  vzz_in_if  in_chan ();
  vzz_out_if out_chan ();

  varint_zigzag_codec uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // codec model state
  logic [63:0] dec_acc;
  logic [3:0]  dec_cnt;
  codec_res_t  step_res [0:9];
  codec_res_t  expected_results [$];

  int errors;
  int in_calm;
  int out_calm;
  bit hold_due;
  bit hold_done;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // gap picker: mostly none, some short, a few long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 60);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic codec_res_t byte_res(logic [7:0] b, logic is_last);
    return '{KIND_BYTE, b, 64'h0, is_last, 1'b0};
  endfunction

  function automatic codec_res_t value_res(logic [63:0] v, logic trunc);
    return '{KIND_VALUE, 8'h00, v, 1'b0, trunc};
  endfunction

  // unused fields carry random bits
  function automatic codec_in_t enc_word(logic [63:0] v, logic sgn, logic wd);
    return '{MODE_ENCODE, v, sgn, wd, 8'($urandom)};
  endfunction

  function automatic codec_in_t dec_word(logic [7:0] b, logic sgn, logic wd);
    return '{MODE_DECODE, {$urandom, $urandom}, sgn, wd, b};
  endfunction

  // model of the codec: fills step_res, returns number of results
  function automatic int codec_predict(codec_in_t w);
    logic [63:0] v;
    logic [63:0] acc;
    logic [3:0]  cnt;
    logic [3:0]  lim;
    logic        done;
    logic        trunc;
    int          n;
    n = 0;
    if (w.mode == MODE_ENCODE) begin
      v = w.wide ? w.value : {32'h0, w.value[31:0]};
      // zigzag: most negative maps to all ones within the width
      if (w.is_signed) begin
        if (w.wide) v = (v << 1) ^ {64{v[63]}};
        else v = {32'h0, (v[31:0] << 1) ^ {32{v[31]}}};
      end
      // low group first, continuation on all but the final byte
      while (v >= 64'h80 && n < 9) begin
        step_res[n] = byte_res({1'b1, v[6:0]}, 1'b0);
        n++;
        v = v >> GROUP_BITS;
      end
      step_res[n] = byte_res(v[7:0], 1'b1);
      n++;
    end else begin
      lim = w.wide ? MAX_BYTES_W64 : MAX_BYTES_W32;
      cnt = (dec_cnt > MAX_GROUP_IDX) ? MAX_GROUP_IDX : dec_cnt;
      // groups above 64 bits fall off the top
      acc = dec_acc | ({57'h0, w.in_byte[6:0]} << (GROUP_BITS * cnt));
      cnt = cnt + 4'd1;
      done  = !w.in_byte[7] || (cnt >= lim);
      trunc = w.in_byte[7] && (cnt >= lim);
      if (!done) begin
        dec_acc = acc;
        dec_cnt = cnt;
      end else begin
        if (!w.wide) acc = {32'h0, acc[31:0]};
        if (w.is_signed) begin
          if (w.wide) begin
            acc = (acc >> 1) ^ {64{acc[0]}};
          end else begin
            acc[31:0]  = (acc[31:0] >> 1) ^ {32{acc[0]}};
            acc[63:32] = {32{acc[31]}};
          end
        end
        step_res[0] = value_res(acc, trunc);
        n = 1;
        dec_acc = '0;
        dec_cnt = '0;
      end
    end
    return n;
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // offer one word, wait for it to be taken, then queue what it should give
  task automatic send_word(input codec_in_t w, input logic typed, input codec_res_t typed_res);
    int gap;
    int n;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.mode      <= w.mode;
    in_chan.value     <= w.value;
    in_chan.is_signed <= w.is_signed;
    in_chan.wide      <= w.wide;
    in_chan.in_byte   <= w.in_byte;
    do @(posedge clk); while (!in_chan.ready);
    n = codec_predict(w);
    if (typed) begin
      expected_results.insert(expected_results.size(), typed_res);
    end else begin
      for (int i = 0; i < n; i++)
        expected_results.insert(expected_results.size(), step_res[i]);
    end
  endtask

  // stimulus
  initial begin
    codec_row_t  rows [$];
    logic [63:0] v;
    logic [7:0]  b;
    logic        sgn;
    logic        wd;
    int          k;
    int          r;
    int          sent;

    errors    = 0;
    in_calm   = 0;
    out_calm  = 0;
    hold_due  = 1'b0;
    hold_done = 1'b0;
    dec_acc   = '0;
    dec_cnt   = '0;
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.mode      <= MODE_ENCODE;
    in_chan.value     <= '0;
    in_chan.is_signed <= 1'b0;
    in_chan.wide      <= 1'b0;
    in_chan.in_byte   <= '0;

    // extremes and encode edge cases
    rows.insert(rows.size(), '{enc_word(64'h0, 1'b0, 1'b0), 1'b1, byte_res(8'h00, 1'b1)});
    rows.insert(rows.size(), '{enc_word(64'h7F, 1'b0, 1'b1), 1'b1, byte_res(8'h7F, 1'b1)});
    rows.insert(rows.size(),
                '{enc_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1), 1'b0, NO_RESULT});
    rows.insert(rows.size(),
                '{enc_word(64'hA5A5_5A5A_FFFF_FFFF, 1'b0, 1'b0), 1'b0, NO_RESULT});
    rows.insert(rows.size(),
                '{enc_word(64'h0000_0000_8000_0000, 1'b1, 1'b0), 1'b0, NO_RESULT});
    rows.insert(rows.size(),
                '{enc_word(64'h8000_0000_0000_0000, 1'b1, 1'b1), 1'b0, NO_RESULT});
    rows.insert(rows.size(), '{enc_word(64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0), 1'b1,
                               byte_res(8'h01, 1'b1)});
    rows.insert(rows.size(), '{enc_word(64'h80, 1'b0, 1'b0), 1'b0, NO_RESULT});
    // single-byte decodes
    rows.insert(rows.size(), '{dec_word(8'h00, 1'b0, 1'b0), 1'b1, value_res(64'h0, 1'b0)});
    rows.insert(rows.size(), '{dec_word(8'h7F, 1'b0, 1'b1), 1'b1, value_res(64'h7F, 1'b0)});
    rows.insert(rows.size(), '{dec_word(8'h01, 1'b1, 1'b0), 1'b1,
                               value_res(64'hFFFF_FFFF_FFFF_FFFF, 1'b0)});
    // encode arriving in the middle of a decode leaves it alone
    rows.insert(rows.size(), '{dec_word(8'h81, 1'b0, 1'b0), 1'b0, NO_RESULT});
    rows.insert(rows.size(), '{enc_word(64'h12, 1'b0, 1'b0), 1'b1, byte_res(8'h12, 1'b1)});
    rows.insert(rows.size(), '{dec_word(8'h01, 1'b0, 1'b0), 1'b0, NO_RESULT});
    // 32-bit decode cut off at the byte limit
    for (int i = 0; i < 4; i++)
      rows.insert(rows.size(), '{dec_word(8'hFF, 1'b0, 1'b0), 1'b0, NO_RESULT});
    rows.insert(rows.size(), '{dec_word(8'hFF, 1'b0, 1'b0), 1'b1,
                               value_res(64'hFFFF_FFFF, 1'b1)});
    // width dropped to 32 bits mid-value
    for (int i = 0; i < 4; i++)
      rows.insert(rows.size(), '{dec_word(8'hFF, 1'b0, 1'b1), 1'b0, NO_RESULT});
    rows.insert(rows.size(), '{dec_word(8'h81, 1'b0, 1'b0), 1'b0, NO_RESULT});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (rows[i]) send_word(rows[i].word, rows[i].typed, rows[i].res);

    // random part: encodes, well-formed decode streams, noise
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent >= 20) hold_due = 1'b1;
      r   = $urandom_range(0, 99);
      sgn = 1'($urandom);
      wd  = 1'($urandom);
      if (r < 40) begin
        v = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) v = v >> $urandom_range(0, 63);
        if (!wd && $urandom_range(0, 1) == 1) v[63:32] = $urandom;
        send_word(enc_word(v, sgn, wd), 1'b0, NO_RESULT);
        sent++;
      end else if (r < 85) begin
        k = $urandom_range(1, wd ? 10 : 5);
        for (int i = 0; i < k; i++) begin
          b = {(i < k - 1), 7'($urandom)};
          send_word(dec_word(b, sgn, wd), 1'b0, NO_RESULT);
          sent++;
        end
      end else begin
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          send_word(dec_word(8'($urandom), 1'($urandom), 1'($urandom)), 1'b0, NO_RESULT);
          sent++;
        end
      end
    end
    in_chan.valid <= 1'b0;

    // drain, then let the pipeline settle
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_results.size()));
    if (errors == 0) begin
      $display("varint_zigzag_codec_test: done, clean");
    end else begin
      $display("varint_zigzag_codec_test: done, errors");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off while input keeps coming
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_due && !hold_done) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      gap = pick_gap(out_calm);
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // result checker and idle watchdog
  initial begin
    codec_res_t got;
    codec_res_t want;
    int         idle_cycles;
    logic       bad;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got = '{vzz_kind_e'(out_chan.out_kind), out_chan.out_byte, out_chan.out_value,
                out_chan.last, out_chan.truncated};
        if (expected_results.size() == 0) begin
          note_error($sformatf("unexpected word kind=%0d byte=%h value=%h last=%b trunc=%b",
                               got.kind, got.enc_byte, got.dec_value, got.last, got.truncated));
        end else begin
          want = expected_results.pop_front();
          bad = (got.kind != want.kind) || (got.enc_byte != want.enc_byte) ||
                (got.dec_value != want.dec_value) || (got.last != want.last) ||
                (got.truncated != want.truncated);
          if (bad)
            note_error($sformatf({"expected kind=%0d byte=%h value=%h last=%b trunc=%b, ",
                                  "got kind=%0d byte=%h value=%h last=%b trunc=%b"},
                                 want.kind, want.enc_byte, want.dec_value, want.last,
                                 want.truncated, got.kind, got.enc_byte, got.dec_value,
                                 got.last, got.truncated));
        end
      end
      // watchdog on cycles with no word moving on either side
      if ((out_chan.valid && out_chan.ready) || (in_chan.valid && in_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("varint_zigzag_codec_test: done, errors");
        $finish;
      end
    end
  end

endmodule

>>> varint_zigzag_codec.f
src/vzz_pkg.sv
src/vzz_if.sv
src/vzz_front.sv
src/vzz_fifo.sv
src/vzz_back.sv
src/varint_zigzag_codec.sv
dv/varint_zigzag_codec_test.sv
